// ===== hw/rtl/rrva_pkg.sv =====
// Shared constants for the round-robin voice allocator.
`timescale 1ns / 1ps

package rrva_pkg;

  localparam int unsigned CFG_W        = 5;
  localparam int unsigned NOTE_W       = 7;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned MASK_W       = 16;
  localparam int unsigned VIU_RESET    = 16;
  localparam int unsigned VIU_LIMIT    = 31;
  localparam int unsigned DROP_STEPS   = 4;

  localparam logic ACT_NOTE_ON  = 1'b0;
  localparam logic ACT_NOTE_OFF = 1'b1;

endpackage

// ===== hw/rtl/rrva_note_mem.sv =====
// Per-voice note store: one write port, one registered read port.
`timescale 1ns / 1ps

module rrva_note_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [rrva_pkg::NOTE_W-1:0]    wr_data_i,
  input  logic [AW-1:0]                  rd_addr_i,
  output logic [rrva_pkg::NOTE_W-1:0]    rd_data_o
);
  import rrva_pkg::*;

  logic [NOTE_W-1:0] mem_q [DEPTH];
  logic [NOTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/round_robin_voice_allocator.sv =====
// Round-robin voice allocator: top level with probe sequencer and note-off scan.
// Throughput: one event at a time; a single advance-and-compare unit probes one voice a cycle.
// The next event is taken once the result has moved into the output register.
// Reset (async, active low): busy marks cleared, pointer 0, voices_in_use 16; notes not cleared.
`timescale 1ns / 1ps

module round_robin_voice_allocator #(
  parameter int unsigned MAX_VOICES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrva_pkg::CFG_W-1:0]    voices_in_use_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [rrva_pkg::NOTE_W-1:0]   note_number_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrva_pkg::IDX_W-1:0]    voice_index_o,
  output logic                          started_o,
  output logic                          dropped_o,
  output logic [rrva_pkg::MASK_W-1:0]   released_mask_o
);
  import rrva_pkg::*;

  localparam int unsigned PW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned EW   = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;
  localparam int unsigned NMAX = (MAX_VOICES < VIU_LIMIT) ? MAX_VOICES : VIU_LIMIT;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ON    = 3'd1;
  localparam logic [2:0] ST_DROP  = 3'd2;
  localparam logic [2:0] ST_OFF   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CFG_W-1:0]  vin_q;
  logic [PW-1:0]     rotate_q;
  logic              busy_q [MAX_VOICES];
  logic              cmp_v_q;
  logic              out_valid_q;

  logic [PW-1:0]     p_q;
  logic [PW-1:0]     cmp_idx_q;
  logic [CFG_W-1:0]  cnt_q;
  logic [NOTE_W-1:0] note_q;
  logic [MASK_W-1:0] mask_q;
  logic              started_q;
  logic              dropped_q;
  logic [IDX_W-1:0]  out_index_q;
  logic              out_started_q;
  logic              out_dropped_q;
  logic [MASK_W-1:0] out_mask_q;

  logic [CFG_W-1:0]  n_w;
  logic [EW-1:0]     p_inc;
  logic              wrap;
  logic [PW-1:0]     p_adv;
  logic [CFG_W-1:0]  cnt_inc;
  logic              on_last;
  logic              drop_last;
  logic              free_hit;
  logic              hit;
  logic              out_free;
  logic [NOTE_W-1:0] rd_note;

  // active voice count, clamped
  assign n_w = (vin_q == '0) ? CFG_W'(1) :
               ((vin_q > CFG_W'(NMAX)) ? CFG_W'(NMAX) : vin_q);

  // shared advance unit
  assign p_inc     = EW'(p_q) + EW'(1);
  assign wrap      = (p_inc >= EW'(n_w));
  assign p_adv     = wrap ? '0 : p_inc[PW-1:0];
  assign cnt_inc   = cnt_q + CFG_W'(1);
  assign on_last   = (cnt_inc == n_w);
  assign drop_last = (cnt_q == CFG_W'(DROP_STEPS - 1));
  assign free_hit  = (state_q == ST_ON) && !busy_q[p_adv];
  assign hit       = cmp_v_q && busy_q[cmp_idx_q] && (rd_note == note_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  rrva_note_mem #(
    .DEPTH (MAX_VOICES),
    .AW    (PW)
  ) u_note_mem (
    .clk_i     (clk_i),
    .wr_en_i   (free_hit),
    .wr_addr_i (p_adv),
    .wr_data_i (note_q),
    .rd_addr_i (p_q),
    .rd_data_o (rd_note)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (action_i == ACT_NOTE_OFF) ? ST_OFF : ST_ON;
        end
      end
      ST_ON: begin
        if (!busy_q[p_adv]) begin
          state_d = ST_FIN;
        end else if (on_last) begin
          state_d = ST_DROP;
        end
      end
      ST_DROP: begin
        if (drop_last) begin
          state_d = ST_FIN;
        end
      end
      ST_OFF: begin
        if (wrap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vin_q       <= CFG_W'(VIU_RESET);
      rotate_q    <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        busy_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      cmp_v_q <= (state_q == ST_OFF);
      if (cfg_valid_i) begin
        vin_q <= voices_in_use_i;
      end
      if (free_hit) begin
        busy_q[p_adv] <= 1'b1;
        rotate_q      <= p_adv;
      end
      if ((state_q == ST_DROP) && drop_last) begin
        rotate_q <= p_adv;
      end
      if (hit) begin
        busy_q[cmp_idx_q] <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= (state_q == ST_FIN);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          note_q    <= note_number_i;
          p_q       <= (action_i == ACT_NOTE_OFF) ? '0 : rotate_q;
          cnt_q     <= '0;
          mask_q    <= '0;
          started_q <= 1'b0;
          dropped_q <= 1'b0;
        end
      end
      ST_ON: begin
        if (!busy_q[p_adv]) begin
          started_q <= 1'b1;
        end else if (on_last) begin
          p_q   <= rotate_q;
          cnt_q <= '0;
        end else begin
          p_q   <= p_adv;
          cnt_q <= cnt_inc;
        end
      end
      ST_DROP: begin
        p_q   <= p_adv;
        cnt_q <= cnt_inc;
        if (drop_last) begin
          dropped_q <= 1'b1;
        end
      end
      ST_OFF: begin
        p_q       <= p_adv;
        cmp_idx_q <= p_q;
      end
      ST_FIN: begin
        if (out_free) begin
          out_index_q   <= started_q ? IDX_W'(rotate_q) : '0;
          out_started_q <= started_q;
          out_dropped_q <= dropped_q;
          out_mask_q    <= mask_q;
        end
      end
      default: ;
    endcase
    if (hit) begin
      mask_q <= mask_q | (MASK_W'(1) << cmp_idx_q);
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign voice_index_o   = out_index_q;
  assign started_o       = out_started_q;
  assign dropped_o       = out_dropped_q;
  assign released_mask_o = out_mask_q;

  // a result comes only from the finishing step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("result beat without finishing step");

  a_start_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(started_o && dropped_o))
    else $error("note-on both started and dropped");

  a_on_no_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (started_o || dropped_o) |-> released_mask_o == '0)
    else $error("release mask on a note-on beat");

  // pointer lands inside the active voices once a note-on finishes
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && (started_q || dropped_q) |-> EW'(rotate_q) < EW'(n_w))
    else $error("rotate pointer outside active voices");

endmodule
